// ----- design/het_pkg.sv -----
// ----------------------------------------------------------------------------
// het_pkg: shared types and constants for the hall edge tachometer
// Request and result payloads, per-channel state entry, memory write port,
// speed unit handshake and the fixed-point constants of the rpm and speed math.
// ----------------------------------------------------------------------------
package het_pkg;

  // Channel addressing: the channel field is one bit wide
  localparam int CH_W     = 1;
  localparam int CH_DEPTH = 2 ** CH_W;
  localparam int CHANNELS = 2;

  // Result widths
  localparam int RPM_W = 17;
  localparam int MPH_W = 19;
  localparam int KPH_W = 18;

  // rpm_q4 = 480000000 / (elapsed * pulses_per_rev), zero below PRODUCT_MIN
  localparam longint RPM_NUM_Q4  = 480000000;
  localparam int     PROD_W      = 40;
  localparam longint PRODUCT_MIN = 6000;
  // Quotient fits RPM_W bits, so the division starts at the top of the dividend
  localparam longint RPM_REM_INIT = RPM_NUM_Q4 / (2 ** RPM_W);
  localparam longint RPM_LOW_INIT = RPM_NUM_Q4 % (2 ** RPM_W);

  // mph divisor 1013760 = 2^11 * 495, kph divisor 1600000 = 2^9 * 3125
  localparam int SCL_W     = 39;
  localparam int MPH_SHIFT = 11;
  localparam int KPH_SHIFT = 9;
  localparam int MPH_Y_W   = SCL_W - MPH_SHIFT;
  localparam int KPH_Y_W   = SCL_W - KPH_SHIFT;

  // Divide by the odd parts with a reciprocal multiply and shift; the
  // rounded-up reciprocals are exact over the full width of the scaled value
  localparam longint MPH_RECIP    = 277654452;   // ceil(2^37 / 495)
  localparam int     MPH_RECIP_SH = 37;
  localparam int     MPH_P_W      = MPH_Y_W + 29;
  localparam longint KPH_RECIP    = 1407374884;  // ceil(2^42 / 3125)
  localparam int     KPH_RECIP_SH = 42;
  localparam int     KPH_P_W      = KPH_Y_W + 31;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMEOUT  = 2'd0,
    CFG_PPR      = 2'd1,
    CFG_CIRC_IN  = 2'd2,
    CFG_CIRC_CM  = 2'd3
  } cfg_idx_t;

  typedef logic [CH_W-1:0] ch_t;

  typedef struct packed {
    logic        channel;
    logic        level;
    logic [31:0] now_us;
  } in_t;

  typedef struct packed {
    logic             out_channel;
    logic [RPM_W-1:0] rpm_q4;
    logic [MPH_W-1:0] mph_x100;
    logic [KPH_W-1:0] kph_x100;
    logic             edge_seen;
    logic             timed_out;
  } out_t;

  // Per-channel state entry
  typedef struct packed {
    logic             level;
    logic [31:0]      last_edge;
    logic [31:0]      deadline;
    logic [RPM_W-1:0] rpm;
    logic [MPH_W-1:0] mph;
    logic [KPH_W-1:0] kph;
  } ent_t;

  typedef struct packed {
    logic en;
    ch_t  addr;
    ent_t data;
  } mem_wr_t;

  typedef struct packed {
    logic        start;
    logic [31:0] elapsed;
    logic [7:0]  ppr;
    logic [15:0] circ_in;
    logic [15:0] circ_cm;
  } spd_req_t;

  typedef struct packed {
    logic             done;
    logic [RPM_W-1:0] rpm;
    logic [MPH_W-1:0] mph;
    logic [KPH_W-1:0] kph;
  } spd_rsp_t;

endpackage

// ----- design/het_mem.sv -----
// ----------------------------------------------------------------------------
// het_mem: per-channel state memory
// Synchronous memory, one write and one read port, read data registered.
// A valid bit per entry makes never-written entries read as all zero.
// ----------------------------------------------------------------------------
module het_mem (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  het_pkg::ch_t     rd_addr,
  output het_pkg::ent_t    rd_data,
  input  het_pkg::mem_wr_t wr
);

  het_pkg::ent_t                  mem_r [het_pkg::CH_DEPTH];
  logic [het_pkg::CH_DEPTH-1:0]   vld_r;
  het_pkg::ent_t                  rd_data_r;
  logic                           rd_vld_r;

  // Store entries
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
  end

  // Mark written entries, register read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  // Unwritten entries read as reset state
  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

// ----- design/het_speed.sv -----
// ----------------------------------------------------------------------------
// het_speed: rpm and speed computation unit
// Multiplies elapsed time by pulses per revolution, divides serially for rpm,
// scales by the wheel circumferences and divides by the odd parts of the mph
// and kph constants with one reciprocal multiply each.
// ----------------------------------------------------------------------------
module het_speed (
  input  logic              clk,
  input  logic              rst_n,
  input  het_pkg::spd_req_t req,
  output het_pkg::spd_rsp_t rsp
);

  typedef enum logic [2:0] {
    SP_IDLE,
    SP_MUL,
    SP_CHK,
    SP_DIV,
    SP_SCL1,
    SP_SCL2,
    SP_RECIP,
    SP_DONE
  } sp_state_t;

  localparam int CNT_W = $clog2(het_pkg::RPM_W + 1);

  sp_state_t                         state_r;
  logic [CNT_W-1:0]                  cnt_r;
  logic [31:0]                       el_r;
  logic [7:0]                        ppr_r;
  logic [15:0]                       cin_r;
  logic [15:0]                       ccm_r;
  logic [het_pkg::PROD_W-1:0]        prod_r;
  logic [het_pkg::PROD_W-1:0]        rem_r;
  logic [het_pkg::RPM_W-1:0]         rq_r;
  logic [32:0]                       am_r;
  logic [32:0]                       ak_r;
  logic [het_pkg::MPH_Y_W-1:0]       ym_r;
  logic [het_pkg::KPH_Y_W-1:0]       yk_r;
  logic [het_pkg::MPH_W-1:0]         qm_r;
  logic [het_pkg::KPH_W-1:0]         qk_r;

  logic [het_pkg::PROD_W:0]          rt;
  logic                              rge;
  logic [het_pkg::SCL_W-1:0]         am60;
  logic [het_pkg::SCL_W-1:0]         ak60;
  logic [het_pkg::MPH_P_W-1:0]       pm;
  logic [het_pkg::KPH_P_W-1:0]       pk;

  // One restoring step of the rpm division
  assign rt  = {rem_r, rq_r[het_pkg::RPM_W-1]};
  assign rge = (rt >= {1'b0, prod_r});

  // Scale by 60 with shift and subtract
  assign am60 = ({6'd0, am_r} << 6) - ({6'd0, am_r} << 2);
  assign ak60 = ({6'd0, ak_r} << 6) - ({6'd0, ak_r} << 2);

  // Reciprocal products for the odd parts of the divisors
  assign pm = het_pkg::MPH_P_W'(ym_r) * het_pkg::MPH_P_W'(het_pkg::MPH_RECIP);
  assign pk = het_pkg::KPH_P_W'(yk_r) * het_pkg::KPH_P_W'(het_pkg::KPH_RECIP);

  // Sequence the computation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SP_IDLE;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        SP_IDLE: begin
          if (req.start) begin
            state_r <= SP_MUL;
          end
        end
        SP_MUL: begin
          state_r <= SP_CHK;
        end
        SP_CHK: begin
          if (prod_r < het_pkg::PROD_W'(het_pkg::PRODUCT_MIN)) begin
            state_r <= SP_SCL1;
          end else begin
            cnt_r   <= CNT_W'(het_pkg::RPM_W);
            state_r <= SP_DIV;
          end
        end
        SP_DIV: begin
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == CNT_W'(1)) begin
            state_r <= SP_SCL1;
          end
        end
        SP_SCL1: begin
          state_r <= SP_SCL2;
        end
        SP_SCL2: begin
          state_r <= SP_RECIP;
        end
        SP_RECIP: begin
          state_r <= SP_DONE;
        end
        SP_DONE: begin
          state_r <= SP_IDLE;
        end
        default: begin
          state_r <= SP_IDLE;
        end
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state_r)
      SP_IDLE: begin
        if (req.start) begin
          el_r  <= req.elapsed;
          ppr_r <= req.ppr;
          cin_r <= req.circ_in;
          ccm_r <= req.circ_cm;
        end
      end
      SP_MUL: begin
        prod_r <= el_r * ppr_r;
      end
      SP_CHK: begin
        rem_r <= het_pkg::PROD_W'(het_pkg::RPM_REM_INIT);
        if (prod_r < het_pkg::PROD_W'(het_pkg::PRODUCT_MIN)) begin
          rq_r <= '0;
        end else begin
          rq_r <= het_pkg::RPM_W'(het_pkg::RPM_LOW_INIT);
        end
      end
      SP_DIV: begin
        if (rge) begin
          rem_r <= het_pkg::PROD_W'(rt - {1'b0, prod_r});
        end else begin
          rem_r <= rt[het_pkg::PROD_W-1:0];
        end
        rq_r <= {rq_r[het_pkg::RPM_W-2:0], rge};
      end
      SP_SCL1: begin
        am_r <= rq_r * cin_r;
        ak_r <= rq_r * ccm_r;
      end
      SP_SCL2: begin
        // Drop the power-of-two factor of each divisor
        ym_r <= am60[het_pkg::SCL_W-1:het_pkg::MPH_SHIFT];
        yk_r <= ak60[het_pkg::SCL_W-1:het_pkg::KPH_SHIFT];
      end
      SP_RECIP: begin
        qm_r <= pm[het_pkg::MPH_RECIP_SH +: het_pkg::MPH_W];
        qk_r <= pk[het_pkg::KPH_RECIP_SH +: het_pkg::KPH_W];
      end
      default: begin
      end
    endcase
  end

  assign rsp.done = (state_r == SP_DONE);
  assign rsp.rpm  = rq_r;
  assign rsp.mph  = qm_r;
  assign rsp.kph  = qk_r;

endmodule

// ----- design/hall_edge_tachometer.sv -----
// ----------------------------------------------------------------------------
// hall_edge_tachometer: per-channel period-measuring tachometer
// Each request is one poll of a sensor level with a timestamp; an edge
// yields rpm, mph and kph readings, a missed deadline zeroes them.
//
//   Channel   Ports                            Direction  Payload
//   request   in_valid / in_ready / in_data    in         het_pkg::in_t
//   result    out_valid / out_ready / out_data out        het_pkg::out_t
//   config    cfg_we / cfg_index / cfg_data    in         32-bit write
//
// A poll without an edge reads the channel entry and returns its stored
// readings; a poll with an edge also runs het_speed: multiply, range check,
// serial rpm division (17 steps), scaling, reciprocal multiply and hand-back,
// with the division skipped when the product is under the rpm limit.
// One request is in flight at a time; the next is accepted once the result
// sits in the output register.
// Reset clears the configuration to its defaults and all channel state.
// A stalled result holds in the output register; the next result then waits in S_DONE and blocks further requests.
// ----------------------------------------------------------------------------
module hall_edge_tachometer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  het_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output het_pkg::out_t                   out_data,
  input  logic                            cfg_we,
  input  logic [het_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                     cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CALC,
    S_DONE
  } state_t;

  state_t            state_r;
  het_pkg::in_t      in_r;
  het_pkg::out_t     res_r;
  het_pkg::out_t     out_data_r;
  logic              out_valid_r;
  logic [31:0]       timeout_r;
  logic [7:0]        ppr_r;
  logic [15:0]       cin_r;
  logic [15:0]       ccm_r;

  het_pkg::ent_t     rd_data;
  het_pkg::mem_wr_t  wr;
  het_pkg::spd_req_t req;
  het_pkg::spd_rsp_t rsp;
  het_pkg::out_t     read_res;
  logic              accept;
  logic              ch_ok;
  logic              edge_hit;
  logic              tmo_hit;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign ch_ok    = (32'(in_r.channel) < het_pkg::CHANNELS);
  assign edge_hit = ch_ok && (in_r.level != rd_data.level);
  assign tmo_hit  = ch_ok && !edge_hit && (in_r.now_us > rd_data.deadline);

  het_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (het_pkg::ch_t'(in_data.channel)),
    .rd_data (rd_data),
    .wr      (wr)
  );

  // Start the speed unit on an edge
  always_comb begin
    req.start   = (state_r == S_READ) && edge_hit;
    req.elapsed = in_r.now_us - rd_data.last_edge;
    req.ppr     = ppr_r;
    req.circ_in = cin_r;
    req.circ_cm = ccm_r;
  end

  het_speed u_speed (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  // Write back the channel entry on timeout or on a finished edge
  always_comb begin
    wr = '0;
    wr.addr = het_pkg::ch_t'(in_r.channel);
    if ((state_r == S_READ) && tmo_hit) begin
      wr.en             = 1'b1;
      wr.data           = '0;
      wr.data.level     = rd_data.level;
      wr.data.last_edge = in_r.now_us;
      wr.data.deadline  = rd_data.deadline;
    end else if ((state_r == S_CALC) && rsp.done) begin
      wr.en             = 1'b1;
      wr.data.level     = in_r.level;
      wr.data.last_edge = in_r.now_us;
      wr.data.deadline  = in_r.now_us + timeout_r;
      wr.data.rpm       = rsp.rpm;
      wr.data.mph       = rsp.mph;
      wr.data.kph       = rsp.kph;
    end
  end

  // Result of a poll without an edge: stored readings, or zero on timeout
  always_comb begin
    read_res             = '0;
    read_res.out_channel = in_r.channel;
    if (ch_ok && !tmo_hit) begin
      read_res.rpm_q4   = rd_data.rpm;
      read_res.mph_x100 = rd_data.mph;
      read_res.kph_x100 = rd_data.kph;
    end
    read_res.timed_out = tmo_hit;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= 32'd1000000;
      ppr_r     <= 8'd45;
      cin_r     <= 16'd2500;
      ccm_r     <= 16'd6350;
    end else if (cfg_we) begin
      unique case (het_pkg::cfg_idx_t'(cfg_index))
        het_pkg::CFG_TIMEOUT: timeout_r <= cfg_data;
        het_pkg::CFG_PPR:     ppr_r     <= cfg_data[7:0];
        het_pkg::CFG_CIRC_IN: cin_r     <= cfg_data[15:0];
        het_pkg::CFG_CIRC_CM: ccm_r     <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // Sequence one request: read, decide, compute, deliver
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            in_r    <= in_data;
            state_r <= S_READ;
          end
        end
        S_READ: begin
          if (edge_hit) begin
            state_r <= S_CALC;
          end else begin
            res_r   <= read_res;
            state_r <= S_DONE;
          end
        end
        S_CALC: begin
          if (rsp.done) begin
            res_r   <= '{out_channel: in_r.channel, rpm_q4: rsp.rpm,
                         mph_x100: rsp.mph, kph_x100: rsp.kph,
                         edge_seen: 1'b1, timed_out: 1'b0};
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_data_r  <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking regression for the hall edge tachometer
// Drives sensor polls through the request channel and checks each result
// against an in-bench tachometer model: a directed table of edge, timeout,
// wrap and extreme cases first, then random pulse trains over several
// register settings, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
  import het_pkg::*;

  localparam int          HALF_PERIOD   = 4;
  localparam int          RESET_CYCLES  = 6;
  localparam int          SETTLE_CYCLES = 64;
  localparam int          PHASES        = 6;
  localparam int          PHASE_POLLS   = 300;
  localparam longint      WATCHDOG_NS   = 64'd8_000_000;

  // Fixed-point constants of the rpm and speed arithmetic
  localparam logic [63:0] RPM_DIVIDEND  = 64'd480_000_000;
  localparam logic [63:0] PRODUCT_FLOOR = 64'd6000;
  localparam logic [63:0] MPH_DIVISOR   = 64'd1_013_760;
  localparam logic [63:0] KPH_DIVISOR   = 64'd1_600_000;
  localparam logic [63:0] SEC_PER_MIN   = 64'd60;

  typedef struct packed {
    logic [31:0] timeout;
    logic [7:0]  ppr;
    logic [15:0] circ_in;
    logic [15:0] circ_cm;
  } tach_cfg_t;

  typedef enum logic [0:0] {ROW_POLL, ROW_CONFIG} row_kind_t;

  typedef struct {
    row_kind_t kind;
    in_t       poll;
    bit        fixed;
    out_t      want;
    tach_cfg_t cfg;
  } dir_row_t;

  logic  clk       = 1'b0;
  logic  rst_n     = 1'b0;
  logic  in_valid  = 1'b0;
  logic  in_ready;
  in_t   in_data   = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  out_t  out_data;
  logic  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data  = '0;

  // Model copy of the registers and of the per-channel state
  tach_cfg_t        cur_cfg = {32'd1_000_000, 8'd45, 16'd2500, 16'd6350};
  logic             ch_level    [CHANNELS] = '{default: '0};
  logic [31:0]      ch_last_edge[CHANNELS] = '{default: '0};
  logic [31:0]      ch_deadline [CHANNELS] = '{default: '0};
  logic [RPM_W-1:0] ch_rpm      [CHANNELS] = '{default: '0};
  logic [MPH_W-1:0] ch_mph      [CHANNELS] = '{default: '0};
  logic [KPH_W-1:0] ch_kph      [CHANNELS] = '{default: '0};

  out_t     readings_due[$];
  out_t     head_due;
  int       mismatch_count = 0;
  bit       steady = 1'b0;
  dir_row_t dir_rows[$];
  tach_cfg_t phase_cfg[PHASES];

  hall_edge_tachometer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Advance the model by one poll and return the reading it reports
  function automatic out_t predict_reading(in_t p);
    out_t        r;
    logic [31:0] elapsed;
    logic [63:0] product;
    logic [63:0] rpm;
    r = '0;
    r.out_channel = p.channel;
    if (p.level != ch_level[p.channel]) begin
      elapsed = p.now_us - ch_last_edge[p.channel];
      product = 64'(elapsed) * 64'(cur_cfg.ppr);
      rpm     = (product >= PRODUCT_FLOOR) ? RPM_DIVIDEND / product : 64'd0;
      ch_rpm[p.channel] = rpm[RPM_W-1:0];
      ch_mph[p.channel] = MPH_W'((64'(cur_cfg.circ_in) * rpm * SEC_PER_MIN) / MPH_DIVISOR);
      ch_kph[p.channel] = KPH_W'((64'(cur_cfg.circ_cm) * rpm * SEC_PER_MIN) / KPH_DIVISOR);
      ch_last_edge[p.channel] = p.now_us;
      ch_deadline[p.channel]  = p.now_us + cur_cfg.timeout;
      ch_level[p.channel]     = p.level;
      r.edge_seen = 1'b1;
    end else if (p.now_us > ch_deadline[p.channel]) begin
      // Missed deadline: drop readings, restart the period from now
      ch_rpm[p.channel] = '0;
      ch_mph[p.channel] = '0;
      ch_kph[p.channel] = '0;
      ch_last_edge[p.channel] = p.now_us;
      r.timed_out = 1'b1;
    end
    r.rpm_q4   = ch_rpm[p.channel];
    r.mph_x100 = ch_mph[p.channel];
    r.kph_x100 = ch_kph[p.channel];
    return r;
  endfunction

  function automatic dir_row_t poll_row(bit c, bit l, logic [31:0] t);
    dir_row_t row;
    row.kind  = ROW_POLL;
    row.poll  = {c, l, t};
    row.fixed = 1'b0;
    row.want  = '0;
    row.cfg   = '0;
    return row;
  endfunction

  // Row whose reading is all zero, with the given edge and timeout flags
  function automatic dir_row_t fixed_row(bit c, bit l, logic [31:0] t, bit e, bit tmo);
    dir_row_t row;
    row = poll_row(c, l, t);
    row.fixed = 1'b1;
    row.want.out_channel = c;
    row.want.edge_seen   = e;
    row.want.timed_out   = tmo;
    return row;
  endfunction

  function automatic dir_row_t config_row(tach_cfg_t nc);
    dir_row_t row;
    row = poll_row(1'b0, 1'b0, 32'd0);
    row.kind = ROW_CONFIG;
    row.cfg  = nc;
    return row;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want_v,
                             input logic [63:0] got_v);
    if (want_v !== got_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
      mismatch_count++;
    end
  endtask

  // Present one poll request, wait for accept, queue its reading
  task automatic send_poll(input in_t item, input bit fixed, input out_t want);
    out_t predicted;
    if (!steady && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    predicted = predict_reading(item);
    readings_due.push_back(fixed ? want : predicted);
  endtask

  // Hold off requests until every reading is back and the block is quiet
  task automatic drain_results();
    in_valid <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(input tach_cfg_t nc);
    cfg_idx_t    idx [4];
    logic [31:0] vals[4];
    idx  = '{CFG_TIMEOUT, CFG_PPR, CFG_CIRC_IN, CFG_CIRC_CM};
    vals = '{nc.timeout, 32'(nc.ppr), 32'(nc.circ_in), 32'(nc.circ_cm)};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we  <= 1'b0;
    cur_cfg = nc;
  endtask

  // Check each accepted reading against the oldest one due; vary out_ready
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (readings_due.size() == 0) begin
        $error("reading for channel %0d with no request pending", out_data.out_channel);
        mismatch_count++;
      end else begin
        head_due = readings_due.pop_front();
        check_field("out_channel", head_due.out_channel, out_data.out_channel);
        check_field("rpm_q4",      head_due.rpm_q4,      out_data.rpm_q4);
        check_field("mph_x100",    head_due.mph_x100,    out_data.mph_x100);
        check_field("kph_x100",    head_due.kph_x100,    out_data.kph_x100);
        check_field("edge_seen",   head_due.edge_seen,   out_data.edge_seen);
        check_field("timed_out",   head_due.timed_out,   out_data.timed_out);
      end
    end
    out_ready <= steady || ($urandom_range(99) >= 36);
  end

  initial begin
    #(WATCHDOG_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [31:0] gen_time [CHANNELS];
    logic        gen_level[CHANNELS];
    in_t         item;
    int unsigned base;
    int unsigned roll;
    bit          c;

    // Directed table: reset state, zero elapsed, threshold, wrap, extremes
    dir_rows.push_back(fixed_row(1'b0, 1'b0, 32'd0, 1'b0, 1'b0));
    dir_rows.push_back(fixed_row(1'b1, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b1));
    dir_rows.push_back(fixed_row(1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0));
    dir_rows.push_back(fixed_row(1'b1, 1'b1, 32'd999_999, 1'b0, 1'b0));
    dir_rows.push_back(fixed_row(1'b1, 1'b1, 32'd1_000_000, 1'b0, 1'b1));
    dir_rows.push_back(fixed_row(1'b1, 1'b0, 32'd1_000_133, 1'b1, 1'b0));
    dir_rows.push_back(poll_row(1'b1, 1'b1, 32'd1_000_267));
    dir_rows.push_back(poll_row(1'b1, 1'b0, 32'd1_020_267));
    dir_rows.push_back(poll_row(1'b0, 1'b1, 32'd12_345));
    dir_rows.push_back(poll_row(1'b0, 1'b0, 32'd13_678));
    dir_rows.push_back(fixed_row(1'b0, 1'b0, 32'h8000_0000, 1'b0, 1'b1));
    dir_rows.push_back(config_row({32'd1, 8'd1, 16'hFFFF, 16'hFFFF}));
    dir_rows.push_back(poll_row(1'b0, 1'b1, 32'h8000_0000 + 32'd6000));
    dir_rows.push_back(poll_row(1'b0, 1'b1, 32'h8000_0000 + 32'd6001));
    dir_rows.push_back(fixed_row(1'b0, 1'b1, 32'h8000_0000 + 32'd6002, 1'b0, 1'b1));
    dir_rows.push_back(config_row({32'hFFFF_FFFF, 8'd0, 16'd0, 16'hFFFF}));
    dir_rows.push_back(fixed_row(1'b1, 1'b1, 32'd5000, 1'b1, 1'b0));
    dir_rows.push_back(fixed_row(1'b1, 1'b1, 32'd5000, 1'b0, 1'b1));
    dir_rows.push_back(config_row({32'd500, 8'd255, 16'd0, 16'hFFFF}));
    dir_rows.push_back(poll_row(1'b0, 1'b0, 32'h8000_0000 + 32'd100));
    dir_rows.push_back(poll_row(1'b0, 1'b1, 32'h8000_0000 + 32'd124));
    dir_rows.push_back(fixed_row(1'b0, 1'b0, 32'h8000_0000 + 32'd147, 1'b1, 1'b0));
    dir_rows.push_back(fixed_row(1'b1, 1'b1, 32'hFFFF_FF00, 1'b0, 1'b1));
    dir_rows.push_back(poll_row(1'b1, 1'b0, 32'h0000_0010));
    dir_rows.push_back(fixed_row(1'b1, 1'b0, 32'hFFFF_FFFF, 1'b0, 1'b1));

    // Register settings of the random phases; the last one runs without gaps
    phase_cfg[0] = {32'd1_000_000, 8'd45, 16'd2500, 16'd6350};
    phase_cfg[1] = {32'd2000, 8'd1, 16'hFFFF, 16'hFFFF};
    phase_cfg[2] = {32'hFFFF_FFFF, 8'd255, 16'd1, 16'd1};
    phase_cfg[3] = {32'($urandom_range(500, 200_000)), 8'($urandom_range(1, 255)),
                    16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535))};
    phase_cfg[4] = {32'd1, 8'($urandom_range(1, 255)),
                    16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535))};
    phase_cfg[5] = {32'($urandom_range(1000, 50_000)), 8'($urandom_range(1, 255)),
                    16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535))};

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CONFIG) begin
        drain_results();
        program_regs(dir_rows[i].cfg);
      end else begin
        send_poll(dir_rows[i].poll, dir_rows[i].fixed, dir_rows[i].want);
      end
    end

    // Random pulse trains, mostly well-formed, with jumps and noise
    gen_time  = '{default: '0};
    gen_level = '{default: '0};
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      program_regs(phase_cfg[ph]);
      steady = (ph == PHASES - 1);
      base   = 6000 / cur_cfg.ppr + 1;
      for (int n = 0; n < PHASE_POLLS; n++) begin
        c    = $urandom_range(1);
        roll = $urandom_range(99);
        if (roll < 70) begin
          // Regular poll: advance time, toggle the sensor now and then
          gen_time[c] += $urandom_range(0, base * 3);
          if ($urandom_range(99) < 45) gen_level[c] = ~gen_level[c];
        end else if (roll < 80) begin
          // Quiet sensor past the deadline
          gen_time[c] += cur_cfg.timeout + $urandom_range(1, base * 3);
        end else if (roll < 88) begin
          // Edge at the same instant as the last poll
          gen_level[c] = ~gen_level[c];
        end else begin
          gen_time[c]  = $urandom;
          gen_level[c] = $urandom_range(1);
        end
        item.channel = c;
        item.level   = gen_level[c];
        item.now_us  = gen_time[c];
        send_poll(item, 1'b0, '0);
      end
    end

    drain_results();
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
